>>> hw/rtl/lsrd_pkg.sv
// Shared codes, constants and saturating arithmetic helpers for the redistancing sweep.
`timescale 1ns / 1ps

package lsrd_pkg;

   // Item function codes.
   localparam logic [1:0] FUNC_WRITE = 2'd0;
   localparam logic [1:0] FUNC_RUN   = 2'd1;
   localparam logic [1:0] FUNC_READ  = 2'd2;

   // Configuration register indexes.
   localparam logic [1:0] CSR_GRID_SPACING   = 2'd0;
   localparam logic [1:0] CSR_DISTANCE_LIMIT = 2'd1;
   localparam logic [1:0] CSR_GRID_SIZE      = 2'd2;

   // Register reset values.
   localparam logic [30:0] SPACING_RESET = 31'd1024;
   localparam logic [30:0] LIMIT_RESET   = 31'd655360;
   localparam logic [6:0]  SIZE_RESET    = 7'd64;

   // Divider geometry: a 63-bit dividend over a 33-bit divisor.
   localparam int          NUM_W    = 63;
   localparam int          DEN_W    = 33;
   localparam logic [5:0]  DIV_LAST = 6'(NUM_W - 1);

   // Saturate a 34-bit signed sum to the signed 32-bit range.
   function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
      logic signed [31:0] r;
      begin
         if (v > $signed(34'h0_7FFF_FFFF)) begin
            r = 32'sh7FFF_FFFF;
         end else if (v < $signed(34'h3_8000_0000)) begin
            r = 32'sh8000_0000;
         end else begin
            r = v[31:0];
         end
         return r;
      end
   endfunction

   // Magnitude of a signed 32-bit value; the most negative value maps to 2^31.
   function automatic logic [31:0] mag32(input logic signed [31:0] v);
      logic [31:0] r;
      begin
         r = v[31] ? (~v + 32'd1) : v;
         return r;
      end
   endfunction

   // Candidate src + sgn(s) * h replaces dst when its magnitude is smaller.
   function automatic logic signed [31:0] relax(input logic signed [31:0] src,
                                                input logic signed [31:0] dst,
                                                input logic signed [31:0] s,
                                                input logic [30:0]        h);
      logic signed [33:0] src_x;
      logic signed [33:0] h_x;
      logic signed [33:0] sum;
      logic signed [31:0] cand;
      begin
         src_x = $signed({{2{src[31]}}, src});
         h_x   = $signed({3'b000, h});
         if (s > 0) begin
            sum = src_x + h_x;
         end else if (s < 0) begin
            sum = src_x - h_x;
         end else begin
            sum = src_x;
         end
         cand = sat32(sum);
         return (mag32(cand) < mag32(dst)) ? cand : dst;
      end
   endfunction

endpackage

>>> hw/rtl/level_set_redistance_sweep.sv
// Top level of the level-set redistancing engine: grids, sequencer and shared divider.
`timescale 1ns / 1ps

// Usage. Transactions enter on the req_ channel (req_valid / req_stall) and every one
// of them returns exactly one transaction on the rsp_ channel (rsp_valid / rsp_stall).
// A write transaction stores req_sample_value into the input grid and answers zero in
// the cycle after acceptance. A read transaction answers with the redistanced value
// through the ST_READ state and then the output register; rsp_result_valid is set only
// for an in-grid cell after a completed run. A run transaction walks the grid with one
// sequencer: the forward sweep steps each cell through ST_F_A to ST_F_D, ST_SEED,
// ST_RELR, ST_WRR and ST_WRD, and each sign crossing it seeds passes through ST_MUL,
// the single restoring divider in ST_DIV (one quotient bit per cycle) and ST_SFIN;
// the backward sweep steps each cell through ST_B_A to ST_B_D, and the two corner fixes
// each read and then write one cell. req_stall stays high for the whole run.
// The output register holds a finished result while the receiver stalls; the next
// transaction is taken once that register is empty or being drained. The csr_ port
// is always ready, to be written only while the block is idle (not enforced). Synchronous
// reset restores the register defaults and clears the run-done flag; the grid memories
// keep their contents, and a run must follow a complete load of the input grid.

module level_set_redistance_sweep
   import lsrd_pkg::*;
#(
   parameter int GRID_SIZE = 64
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_func,
   input  logic [5:0]         req_row,
   input  logic [5:0]         req_col,
   input  logic signed [31:0] req_sample_value,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_result_value,
   output logic               rsp_result_valid,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [1:0]         csr_index,
   input  logic [31:0]        csr_wdata
);

   localparam int IW     = $clog2(GRID_SIZE);
   localparam int NW     = $clog2(GRID_SIZE + 1);
   localparam int CELLS  = GRID_SIZE * GRID_SIZE;
   localparam int ADDR_W = $clog2(CELLS);
   localparam logic [ADDR_W-1:0] G_A = ADDR_W'(GRID_SIZE);

   typedef enum logic [20:0] {
      ST_IDLE  = 21'h000001,
      ST_READ  = 21'h000002,
      ST_F_A   = 21'h000004,
      ST_F_B   = 21'h000008,
      ST_F_C   = 21'h000010,
      ST_F_D   = 21'h000020,
      ST_SEED  = 21'h000040,
      ST_MUL   = 21'h000080,
      ST_DIV   = 21'h000100,
      ST_SFIN  = 21'h000200,
      ST_RELR  = 21'h000400,
      ST_WRR   = 21'h000800,
      ST_WRD   = 21'h001000,
      ST_C1_RD = 21'h002000,
      ST_C1_WR = 21'h004000,
      ST_B_A   = 21'h008000,
      ST_B_B   = 21'h010000,
      ST_B_C   = 21'h020000,
      ST_B_D   = 21'h040000,
      ST_C2_RD = 21'h080000,
      ST_C2_WR = 21'h100000
   } state_type;

   // Configuration registers.
   logic [30:0] spacing_ff, spacing_in;
   logic [30:0] limit_ff, limit_in;
   logic [6:0]  size_ff, size_in;

   // Sequencer and datapath registers.
   state_type          state_ff, state_in;
   logic [IW-1:0]      i_ff, i_in, j_ff, j_in;
   logic               sel_ff, sel_in;
   logic signed [31:0] a_ff, a_in, b_ff, b_in, c_ff, c_in;
   logic signed [31:0] cell_ff, cell_in, right_ff, right_in;
   logic [NUM_W-1:0]   num_ff, num_in;
   logic [DEN_W-1:0]   den_ff, den_in, rem_ff, rem_in;
   logic [5:0]         cnt_ff, cnt_in;
   logic               run_done_ff, run_done_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic signed [31:0] rsp_value_ff, rsp_value_in;
   logic               rsp_flag_ff, rsp_flag_in;

   // Grid memories; the work grid also holds the finished distance field.
   logic signed [31:0] input_grid_ff [CELLS];
   logic signed [31:0] work_grid_ff [CELLS];
   logic signed [31:0] in_rdata_ff, wk_rdata_ff;
   logic [ADDR_W-1:0]  in_raddr, wk_raddr, wk_waddr, req_addr;
   logic signed [31:0] wk_wdata;
   logic               wk_we, in_we;

   logic [NW-1:0]      side;
   logic [IW-1:0]      last_idx, pen_idx;
   logic [ADDR_W-1:0]  here, right_a, down_a, left_a, up_a, corner_a;
   logic               accept, req_in_grid, read_hit;
   logic signed [31:0] neg_lim, other, down_init;
   logic [31:0]        a_mag;
   logic signed [32:0] diff;
   logic [DEN_W:0]     rem_sh;
   logic               seed_skip;
   logic [NUM_W-1:0]   q_now;

   // Side of the grid in use, clamped to the supported range.
   always_comb begin
      priority if (int'(size_ff) < 3) begin
         side = NW'(3);
      end else if (int'(size_ff) > GRID_SIZE) begin
         side = NW'(GRID_SIZE);
      end else begin
         side = NW'(size_ff);
      end
   end

   assign last_idx = IW'(side - NW'(1));
   assign pen_idx  = IW'(side - NW'(2));

   assign here     = ADDR_W'(i_ff) * G_A + ADDR_W'(j_ff);
   assign right_a  = here + ADDR_W'(1);
   assign down_a   = here + G_A;
   assign left_a   = here - ADDR_W'(1);
   assign up_a     = here - G_A;
   assign corner_a = ADDR_W'(last_idx) * G_A + ADDR_W'(pen_idx);

   assign req_addr    = ADDR_W'(int'(req_row) * GRID_SIZE + int'(req_col));
   assign req_in_grid = (int'(req_row) < GRID_SIZE) && (int'(req_col) < GRID_SIZE);
   assign read_hit    = run_done_ff && (int'(req_row) < int'(side))
                        && (int'(req_col) < int'(side));

   assign req_stall = (state_ff != ST_IDLE) || (rsp_valid_ff && rsp_stall);
   assign accept    = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_value = rsp_value_ff;
   assign rsp_result_valid = rsp_flag_ff;

   assign neg_lim = -$signed({1'b0, limit_ff});

   // Seed arithmetic: the crossing partner is the right sample first, then the lower one.
   assign other     = sel_ff ? c_ff : b_ff;
   assign seed_skip = ((a_ff > 0) && (other > 0)) || ((a_ff < 0) && (other < 0))
                      || (a_ff == other);
   assign a_mag     = mag32(a_ff);
   assign diff      = $signed({other[31], other}) - $signed({a_ff[31], a_ff});
   assign rem_sh    = {rem_ff, num_ff[NUM_W-1]};
   assign q_now     = num_ff;

   always_comb begin
      if (c_ff > 0) begin
         down_init = $signed({1'b0, limit_ff});
      end else if (c_ff < 0) begin
         down_init = neg_lim;
      end else begin
         down_init = 32'sd0;
      end
   end

   // Memory read addresses follow the sequencer; read data is registered and lands in the next cycle.
   always_comb begin
      unique case (state_ff)
         ST_F_B, ST_B_B: in_raddr = (state_ff == ST_F_B) ? right_a : left_a;
         ST_F_C:         in_raddr = down_a;
         ST_B_C:         in_raddr = up_a;
         default:        in_raddr = here;
      endcase
   end

   always_comb begin
      unique case (state_ff)
         ST_IDLE:  wk_raddr = req_addr;
         ST_F_B:   wk_raddr = right_a;
         ST_C1_RD: wk_raddr = corner_a;
         ST_B_B:   wk_raddr = left_a;
         ST_B_C:   wk_raddr = up_a;
         ST_C2_RD: wk_raddr = ADDR_W'(1);
         default:  wk_raddr = here;
      endcase
   end

   // Work grid writes.
   always_comb begin
      wk_we    = 1'b0;
      wk_waddr = here;
      wk_wdata = cell_ff;
      unique case (state_ff)
         ST_RELR: begin
            wk_we = 1'b1;
         end
         ST_WRR: begin
            wk_we    = 1'b1;
            wk_waddr = right_a;
            wk_wdata = right_ff;
         end
         ST_WRD: begin
            wk_we    = 1'b1;
            wk_waddr = down_a;
            wk_wdata = relax(cell_ff, down_init, c_ff, spacing_ff);
         end
         ST_C1_WR: begin
            wk_we    = 1'b1;
            wk_waddr = corner_a + ADDR_W'(1);
            wk_wdata = sat32($signed({{2{wk_rdata_ff[31]}}, wk_rdata_ff})
                             - $signed({3'b000, spacing_ff}));
         end
         ST_B_C: begin
            wk_we    = 1'b1;
            wk_waddr = left_a;
            wk_wdata = relax(cell_ff, wk_rdata_ff, in_rdata_ff, spacing_ff);
         end
         ST_B_D: begin
            wk_we    = 1'b1;
            wk_waddr = up_a;
            wk_wdata = relax(cell_ff, wk_rdata_ff, in_rdata_ff, spacing_ff);
         end
         ST_C2_WR: begin
            wk_we    = 1'b1;
            wk_waddr = '0;
            wk_wdata = sat32($signed({{2{wk_rdata_ff[31]}}, wk_rdata_ff})
                             - $signed({3'b000, spacing_ff}));
         end
         default: begin
            wk_we = 1'b0;
         end
      endcase
   end

   assign in_we = accept && (req_func == FUNC_WRITE) && req_in_grid;

   always_ff @(posedge clock) begin
      if (in_we) begin
         input_grid_ff[req_addr] <= req_sample_value;
      end
      in_rdata_ff <= input_grid_ff[in_raddr];
   end

   always_ff @(posedge clock) begin
      if (wk_we) begin
         work_grid_ff[wk_waddr] <= wk_wdata;
      end
      wk_rdata_ff <= work_grid_ff[wk_raddr];
   end

   // Sequencer and datapath next state.
   always_comb begin
      spacing_in   = spacing_ff;
      limit_in     = limit_ff;
      size_in      = size_ff;
      state_in     = state_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      sel_in       = sel_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      c_in         = c_ff;
      cell_in      = cell_ff;
      right_in     = right_ff;
      num_in       = num_ff;
      den_in       = den_ff;
      rem_in       = rem_ff;
      cnt_in       = cnt_ff;
      run_done_in  = run_done_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_value_in = rsp_value_ff;
      rsp_flag_in  = rsp_flag_ff;

      if (csr_valid) begin
         unique case (csr_index)
            CSR_GRID_SPACING:   spacing_in = csr_wdata[30:0];
            CSR_DISTANCE_LIMIT: limit_in   = csr_wdata[30:0];
            CSR_GRID_SIZE:      size_in    = csr_wdata[6:0];
            default:            size_in    = size_ff;
         endcase
      end

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               priority if (req_func == FUNC_RUN) begin
                  i_in     = '0;
                  j_in     = '0;
                  state_in = ST_F_A;
               end else if ((req_func == FUNC_READ) && read_hit) begin
                  state_in = ST_READ;
               end else begin
                  rsp_valid_in = 1'b1;
                  rsp_value_in = 32'sd0;
                  rsp_flag_in  = 1'b0;
               end
            end
         end
         ST_READ: begin
            rsp_valid_in = 1'b1;
            rsp_value_in = wk_rdata_ff;
            rsp_flag_in  = 1'b1;
            state_in     = ST_IDLE;
         end
         ST_F_A: begin
            sel_in   = 1'b0;
            state_in = ST_F_B;
         end
         ST_F_B: begin
            a_in     = in_rdata_ff;
            cell_in  = ((i_ff == '0) && (j_ff == '0)) ? neg_lim : wk_rdata_ff;
            state_in = ST_F_C;
         end
         ST_F_C: begin
            b_in     = in_rdata_ff;
            right_in = ((i_ff == '0) || (j_ff == pen_idx)) ? neg_lim : wk_rdata_ff;
            state_in = ST_F_D;
         end
         ST_F_D: begin
            c_in     = in_rdata_ff;
            state_in = ST_SEED;
         end
         ST_SEED: begin
            if (seed_skip) begin
               if (sel_ff) begin
                  state_in = ST_RELR;
               end else begin
                  sel_in = 1'b1;
               end
            end else begin
               den_in   = diff[32] ? DEN_W'(-diff) : DEN_W'(diff);
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            num_in   = NUM_W'(a_mag) * NUM_W'(spacing_ff);
            rem_in   = '0;
            cnt_in   = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            // Restoring division, one quotient bit per cycle into the dividend register.
            if (rem_sh >= {1'b0, den_ff}) begin
               rem_in = DEN_W'(rem_sh - {1'b0, den_ff});
               num_in = {num_ff[NUM_W-2:0], 1'b1};
            end else begin
               rem_in = rem_sh[DEN_W-1:0];
               num_in = {num_ff[NUM_W-2:0], 1'b0};
            end
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == DIV_LAST) begin
               state_in = ST_SFIN;
            end
         end
         ST_SFIN: begin
            if ({31'd0, mag32(cell_ff)} > q_now) begin
               cell_in = a_ff[31] ? -$signed(q_now[31:0]) : $signed(q_now[31:0]);
            end
            if (sel_ff) begin
               state_in = ST_RELR;
            end else begin
               sel_in   = 1'b1;
               state_in = ST_SEED;
            end
         end
         ST_RELR: begin
            right_in = relax(cell_ff, right_ff, b_ff, spacing_ff);
            state_in = ST_WRR;
         end
         ST_WRR: begin
            state_in = ST_WRD;
         end
         ST_WRD: begin
            if (j_ff == pen_idx) begin
               j_in = '0;
               if (i_ff == pen_idx) begin
                  state_in = ST_C1_RD;
               end else begin
                  i_in     = i_ff + IW'(1);
                  state_in = ST_F_A;
               end
            end else begin
               j_in     = j_ff + IW'(1);
               state_in = ST_F_A;
            end
         end
         ST_C1_RD: begin
            state_in = ST_C1_WR;
         end
         ST_C1_WR: begin
            i_in     = last_idx;
            j_in     = last_idx;
            state_in = ST_B_A;
         end
         ST_B_A: begin
            state_in = ST_B_B;
         end
         ST_B_B: begin
            cell_in  = wk_rdata_ff;
            state_in = ST_B_C;
         end
         ST_B_C: begin
            state_in = ST_B_D;
         end
         ST_B_D: begin
            if (j_ff == IW'(1)) begin
               j_in = last_idx;
               if (i_ff == IW'(1)) begin
                  state_in = ST_C2_RD;
               end else begin
                  i_in     = i_ff - IW'(1);
                  state_in = ST_B_A;
               end
            end else begin
               j_in     = j_ff - IW'(1);
               state_in = ST_B_A;
            end
         end
         ST_C2_RD: begin
            state_in = ST_C2_WR;
         end
         ST_C2_WR: begin
            run_done_in  = 1'b1;
            rsp_valid_in = 1'b1;
            rsp_value_in = 32'sd0;
            rsp_flag_in  = 1'b0;
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         spacing_ff   <= SPACING_RESET;
         limit_ff     <= LIMIT_RESET;
         size_ff      <= SIZE_RESET;
         state_ff     <= ST_IDLE;
         run_done_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         spacing_ff   <= spacing_in;
         limit_ff     <= limit_in;
         size_ff      <= size_in;
         state_ff     <= state_in;
         run_done_ff  <= run_done_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      i_ff         <= i_in;
      j_ff         <= j_in;
      sel_ff       <= sel_in;
      a_ff         <= a_in;
      b_ff         <= b_in;
      c_ff         <= c_in;
      cell_ff      <= cell_in;
      right_ff     <= right_in;
      num_ff       <= num_in;
      den_ff       <= den_in;
      rem_ff       <= rem_in;
      cnt_ff       <= cnt_in;
      rsp_value_ff <= rsp_value_in;
      rsp_flag_ff  <= rsp_flag_in;
   end

endmodule
